>>> rtl/core/serial_line_assembler_macros.svh
// Assertion helpers for the line assembler.
// Each check is sampled on the rising clock and is held off while reset is high.
`ifndef SERIAL_LINE_ASSEMBLER_MACROS_SVH
`define SERIAL_LINE_ASSEMBLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line assembler check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line assembler check failed");

`endif

>>> rtl/core/sla_pkg.sv
package sla_pkg;

   // Line store size; a line holds at most LINE_MAX-1 characters
   localparam int LINE_MAX = 64;
   localparam int FILL_W   = $clog2(LINE_MAX);

   // Field widths of the channels
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int STAMP_W = 32;

   localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_END     = 2'd1,
      KIND_OVERRUN = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_OVERRUN = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_OVERRUN
   } state_type;

   typedef struct packed {
      kind_type             kind;
      logic [BYTE_W-1:0]    line_char;
      logic [LEN_W-1:0]     line_length;
      logic [STAMP_W-1:0]   stamp_ms;
      logic                 last_flag;
   } result_type;

   typedef struct packed {
      logic                 wr_en;
      logic [FILL_W-1:0]    wr_addr;
      logic [BYTE_W-1:0]    wr_data;
      logic                 rd_en;
      logic [FILL_W-1:0]    rd_addr;
   } ram_req_type;

endpackage

>>> rtl/core/sla_line_ram.sv
module sla_line_ram (
   input  logic                        clock,
   input  sla_pkg::ram_req_type        ram_req,
   output logic [sla_pkg::BYTE_W-1:0]  rd_data
);
   import sla_pkg::*;

   logic [BYTE_W-1:0] store_ff [LINE_MAX];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write the incoming character
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         store_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Registered read; hold the data until the next read
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= store_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sla_out_reg.sv
module sla_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sla_pkg::result_type  load_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output sla_pkg::result_type  rsp_data,
   output logic                 free
);
   import sla_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Slot can take a new request when empty or when the current one leaves
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the result; hold it while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> rtl/core/serial_line_assembler.sv
// Channel    Direction  Handshake          Payload
// req_*      in         req_valid/stall    rx_byte (8), now_ms (32)
// rsp_*      out        rsp_valid/stall    kind (2), line_char (8), line_length (6),
//                                          stamp_ms (32), last_flag (1)
//
// An ordinary byte, a carriage return or a byte in overrun is taken while idle; a byte
// that starts an overrun moves to the overrun state, which then loads the overrun result.
// A newline drains the line store at one character per cycle while rsp_ is not stalled,
// through the single read port of the store, and finishes with the end result.
// Reset clears the mode, the fill count and the output slot; the store is not cleared.
// A stall on rsp_ holds the drain; the waiting result stays in the output register
// while new bytes are taken.
`include "serial_line_assembler_macros.svh"

module serial_line_assembler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sla_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic [sla_pkg::STAMP_W-1:0]   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [sla_pkg::BYTE_W-1:0]    rsp_line_char,
   output logic [sla_pkg::LEN_W-1:0]     rsp_line_length,
   output logic [sla_pkg::STAMP_W-1:0]   rsp_stamp_ms,
   output logic                          rsp_last_flag
);
   import sla_pkg::*;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [FILL_W-1:0]    len_ff, len_in;
   logic [FILL_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;

   logic                 req_accept;
   logic                 line_end_taken;
   ram_req_type          ram_req;
   logic [BYTE_W-1:0]    ram_rd_data;
   logic                 out_load;
   result_type           out_result;
   result_type           rsp_data;
   logic                 out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // A newline taken outside overrun ends a line
   assign line_end_taken = req_accept && (req_rx_byte == CH_NL) && (mode_ff != MODE_OVERRUN);

   sla_line_ram u_line_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   sla_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (out_free)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_line_char   = rsp_data.line_char;
   assign rsp_line_length = rsp_data.line_length;
   assign rsp_stamp_ms    = rsp_data.stamp_ms;
   assign rsp_last_flag   = rsp_data.last_flag;

   // Next state, store accesses and result loads
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      fill_in    = fill_ff;
      len_in     = len_ff;
      rd_idx_in  = rd_idx_ff;
      rd_pend_in = rd_pend_ff;
      stamp_in   = stamp_ff;
      ram_req    = '0;
      out_load   = 1'b0;
      out_result = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (mode_ff == MODE_OVERRUN) begin
                  // Drop everything up to the newline
                  if (req_rx_byte == CH_NL) begin
                     mode_in = MODE_IDLE;
                  end
               end else if (req_rx_byte == CH_CR) begin
                  // Drop carriage returns
               end else if (req_rx_byte == CH_NL) begin
                  // Latch the line and start the drain
                  len_in     = fill_ff;
                  stamp_in   = req_now_ms;
                  fill_in    = '0;
                  rd_idx_in  = '0;
                  rd_pend_in = 1'b0;
                  mode_in    = MODE_IDLE;
                  state_in   = ST_DRAIN;
               end else if (fill_ff >= FILL_W'(LINE_MAX - 1)) begin
                  // Line too long: discard it and report once
                  mode_in  = MODE_OVERRUN;
                  fill_in  = '0;
                  state_in = ST_OVERRUN;
               end else begin
                  // Append the character
                  mode_in         = MODE_COLLECT;
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = fill_ff;
                  ram_req.wr_data = req_rx_byte;
                  fill_in         = fill_ff + FILL_W'(1);
               end
            end
         end

         ST_DRAIN: begin
            // Pass the read character on once the output slot is free
            if (rd_pend_ff && out_free) begin
               out_load             = 1'b1;
               out_result.kind      = KIND_CHAR;
               out_result.line_char = ram_rd_data;
            end
            // Advance the read pointer while characters remain
            if ((rd_idx_ff < len_ff) && (!rd_pend_ff || out_load)) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = rd_idx_ff;
               rd_idx_in       = rd_idx_ff + FILL_W'(1);
               rd_pend_in      = 1'b1;
            end else if (out_load) begin
               rd_pend_in = 1'b0;
            end
            // Finish with the end result
            if (!rd_pend_ff && (rd_idx_ff == len_ff) && out_free) begin
               out_load               = 1'b1;
               out_result.kind        = KIND_END;
               out_result.line_length = LEN_W'(len_ff);
               out_result.stamp_ms    = stamp_ff;
               out_result.last_flag   = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         ST_OVERRUN: begin
            if (out_free) begin
               out_load             = 1'b1;
               out_result.kind      = KIND_OVERRUN;
               out_result.last_flag = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mode_ff    <= MODE_IDLE;
         fill_ff    <= '0;
         rd_idx_ff  <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         fill_ff    <= fill_in;
         rd_idx_ff  <= rd_idx_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // Line length and stamp of the line being drained
   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      stamp_ff <= stamp_in;
   end

   `SLA_ASSERT_NOW(a_read_in_line, ram_req.rd_en, (state_ff == ST_DRAIN) && (ram_req.rd_addr < len_ff))
   `SLA_ASSERT_NOW(a_write_when_idle, ram_req.wr_en, (state_ff == ST_IDLE) && !rd_pend_ff)
   `SLA_ASSERT_NOW(a_load_into_free, out_load, !rsp_valid || !rsp_stall)
   `SLA_ASSERT_NOW(a_pend_in_drain, rd_pend_ff, state_ff == ST_DRAIN)
   `SLA_ASSERT_NEXT(a_newline_drains, line_end_taken, state_ff == ST_DRAIN)

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import sla_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int REPORT_LIMIT   = 10;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic [STAMP_W-1:0]   req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_kind;
   logic [BYTE_W-1:0]    rsp_line_char;
   logic [LEN_W-1:0]     rsp_line_length;
   logic [STAMP_W-1:0]   rsp_stamp_ms;
   logic                 rsp_last_flag;

   // Line assembler mirror
   mode_type             rx_mode = MODE_IDLE;
   logic [BYTE_W-1:0]    line_copy [LINE_MAX];
   logic [FILL_W-1:0]    line_fill = '0;
   result_type           line_results_due [$];

   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   int                   bytes_taken = 0;
   int                   mismatch_count = 0;
   int                   quiet_cycles = 0;

   serial_line_assembler DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_line_char   (rsp_line_char),
      .rsp_line_length (rsp_line_length),
      .rsp_stamp_ms    (rsp_stamp_ms),
      .rsp_last_flag   (rsp_last_flag)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void queue_result(kind_type kind, logic [BYTE_W-1:0] ch,
                                        logic [LEN_W-1:0] len, logic [STAMP_W-1:0] stamp,
                                        logic last);
      result_type r;
      r.kind        = kind;
      r.line_char   = ch;
      r.line_length = len;
      r.stamp_ms    = stamp;
      r.last_flag   = last;
      line_results_due.push_back(r);
   endfunction

   // Advance the mirror by one accepted byte and queue what it emits
   function automatic void assemble_byte(logic [BYTE_W-1:0] rx, logic [STAMP_W-1:0] now);
      // in overrun only a newline matters, and it returns silently to idle
      if (rx_mode == MODE_OVERRUN) begin
         if (rx == CH_NL)
            rx_mode = MODE_IDLE;
         return;
      end
      if (rx == CH_CR)
         return;
      // newline: drain the stored characters, then the end marker
      if (rx == CH_NL) begin
         for (int i = 0; i < int'(line_fill); i++)
            queue_result(KIND_CHAR, line_copy[i], '0, '0, 1'b0);
         queue_result(KIND_END, '0, line_fill, now, 1'b1);
         rx_mode   = MODE_IDLE;
         line_fill = '0;
         return;
      end
      rx_mode = MODE_COLLECT;
      // one character too many: drop the line and enter overrun
      if (int'(line_fill) >= LINE_MAX - 1) begin
         rx_mode   = MODE_OVERRUN;
         line_fill = '0;
         queue_result(KIND_OVERRUN, '0, '0, '0, 1'b1);
         return;
      end
      line_copy[line_fill] = rx;
      line_fill = line_fill + 1'b1;
   endfunction

   // Offer one request and hold it until taken
   task automatic send_byte(logic [BYTE_W-1:0] rx, logic [STAMP_W-1:0] now);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      req_now_ms  <= now;
      do
         @(posedge clock);
      while (req_stall);
      assemble_byte(rx, now);
      bytes_taken++;
   endtask

   task automatic send_text_byte();
      logic [BYTE_W-1:0] b;
      do
         b = BYTE_W'($urandom_range(255));
      while (b == CH_NL || b == CH_CR);
      send_byte(b, $urandom);
   endtask

   // Hold the sender until every pending result has drained
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (line_results_due.size() != 0)
         @(posedge clock);
   endtask

   // Receiver back-pressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Compare each accepted result with the oldest one due
   always @(posedge clock) begin : check_results
      result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_results_due.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("unexpected result: kind %0d char %02h len %0d stamp %08h last %0b",
                        rsp_kind, rsp_line_char, rsp_line_length, rsp_stamp_ms,
                        rsp_last_flag);
            mismatch_count++;
         end else begin
            due = line_results_due.pop_front();
            if (rsp_kind !== due.kind || rsp_line_char !== due.line_char ||
                rsp_line_length !== due.line_length || rsp_stamp_ms !== due.stamp_ms ||
                rsp_last_flag !== due.last_flag) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display({"mismatch: expected kind %0d char %02h len %0d stamp %08h ",
                            "last %0b, got kind %0d char %02h len %0d stamp %08h last %0b"},
                           due.kind, due.line_char, due.line_length, due.stamp_ms,
                           due.last_flag, rsp_kind, rsp_line_char, rsp_line_length,
                           rsp_stamp_ms, rsp_last_flag);
               mismatch_count++;
            end
         end
      end
   end

   // Stop a hung run: count cycles where neither channel moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Empty lines, lone carriage returns and extreme timestamps
   task automatic test_empty_lines();
      send_byte(CH_NL, 32'h0000_0000);
      send_byte(CH_CR, 32'h1234_5678);
      send_byte(CH_NL, 32'hFFFF_FFFF);
      send_byte(CH_CR, 32'h0);
      send_byte(CH_CR, 32'h0);
      send_byte(CH_NL, 32'h8000_0001);
   endtask

   // Short lines with zero, all-ones and embedded carriage returns
   task automatic test_short_lines();
      send_byte(8'h00, 32'h0);
      send_byte(CH_CR, 32'h0);
      send_byte(8'hFF, 32'h0);
      send_byte(8'h41, 32'h0);
      send_byte(CH_NL, 32'h5555_AAAA);
      send_byte(8'h5A, 32'h0);
      send_byte(CH_NL, 32'hAAAA_5555);
      send_byte(8'hA5, 32'hFFFF_FFFF);
      send_byte(8'h0B, 32'h0);
      send_byte(8'h0C, 32'h0);
      send_byte(8'h09, 32'h0);
      send_byte(CH_NL, 32'h0000_0001);
   endtask

   // Longest legal line, then one that overruns and recovers
   task automatic test_line_limits();
      for (int i = 0; i < LINE_MAX - 1; i++)
         send_text_byte();
      send_byte(CH_CR, $urandom);
      send_byte(CH_NL, $urandom);
      for (int i = 0; i < LINE_MAX; i++)
         send_text_byte();
      send_byte(CH_CR, $urandom);
      send_byte(8'h00, $urandom);
      send_byte(8'hFF, $urandom);
      send_byte(CH_NL, $urandom);
      send_byte(8'h7E, $urandom);
      send_byte(CH_NL, $urandom);
   endtask

   // Mostly well-formed lines of random content, some noise, now and then a long one
   task automatic test_random_lines(int idle_pct, int stall_rate, int item_count);
      int target;
      int len;
      send_idle_pct = idle_pct;
      stall_pct     = stall_rate;
      target        = bytes_taken + item_count;
      while (bytes_taken < target) begin
         if ($urandom_range(6) == 0) begin
            send_byte(BYTE_W'($urandom_range(255)), $urandom);
         end else begin
            len = ($urandom_range(11) == 0) ? $urandom_range(60, 67) : $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(9) == 0)
                  send_byte(CH_CR, $urandom);
               send_text_byte();
            end
            send_byte(CH_NL, $urandom);
         end
         if ($urandom_range(19) == 0)
            wait_for_drain();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_lines();
      test_short_lines();
      test_line_limits();
      wait_for_drain();
      test_random_lines(0, 0, 10);
      test_random_lines(77, 0, 8);
      test_random_lines(0, 77, 8);
      test_random_lines(27, 27, 8);
      test_random_lines(0, 0, 6);

      // finish: let the last results out, then allow for stragglers
      req_valid <= 1'b0;
      while (line_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
